// ===== src/tsc_pkg.sv =====
// Shared types and codes for the timed sequence cursor.
// Used by tsc_alu, timed_sequence_cursor and the testbench; depends on nothing else.
package tsc_pkg;

  localparam int unsigned ENTRY_DEPTH_DEF = 64;

  localparam int unsigned DUR_W   = 32;
  localparam int unsigned TYPE_W  = 16;
  localparam int unsigned TOTAL_W = 38;
  localparam int unsigned IDX_O_W = 6;

  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_REWIND  = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ALU_ADD32 = 2'd0,
    ALU_ADD38 = 2'd1,
    ALU_SUB   = 2'd2
  } alu_op_e;

  typedef struct packed {
    logic [TOTAL_W-1:0] value;
    logic               gt;
  } alu_res_t;

  typedef struct packed {
    logic [DUR_W-1:0]  dur;
    logic [TYPE_W-1:0] typ;
  } entry_t;

endpackage

// ===== src/tsc_alu.sv =====
// Shared add / subtract / compare unit of the timed sequence cursor.
// Depends on tsc_pkg for the operation codes and the result struct.
module tsc_alu import tsc_pkg::*; (
  input  alu_op_e            op_i,
  input  logic [TOTAL_W-1:0] a_i,
  input  logic [DUR_W-1:0]   b_i,
  output alu_res_t           res_o
);

  logic [TOTAL_W:0] sum38;
  logic [DUR_W:0]   sum32;
  logic [DUR_W:0]   diff;

  assign sum38 = {1'b0, a_i} + (TOTAL_W+1)'(b_i);
  assign sum32 = {1'b0, a_i[DUR_W-1:0]} + {1'b0, b_i};
  assign diff  = {1'b0, a_i[DUR_W-1:0]} - {1'b0, b_i};

  always_comb begin
    // low DUR_W bits of a > b when the subtraction neither borrows nor lands on zero
    res_o.gt = !diff[DUR_W] && (diff[DUR_W-1:0] != '0);
    unique case (op_i)
      ALU_ADD32: begin
        res_o.value = sum32[DUR_W] ? TOTAL_W'({DUR_W{1'b1}})
                                   : TOTAL_W'(sum32[DUR_W-1:0]);
      end
      ALU_ADD38: begin
        res_o.value = sum38[TOTAL_W] ? {TOTAL_W{1'b1}} : sum38[TOTAL_W-1:0];
      end
      ALU_SUB: begin
        res_o.value = TOTAL_W'(diff[DUR_W-1:0]);
      end
      default: begin
        res_o.value = '0;
      end
    endcase
  end

endmodule

// ===== src/timed_sequence_cursor.sv =====
// Top level of the timed sequence cursor: entry memory, sequencer and state.
// Depends on tsc_pkg and instantiates tsc_alu.
//
// Usage: drive cmd_i and its operands with start high while busy is low;
// the item is taken at that edge and busy rises the cycle after. One result
// per item appears on the result ports while done_o is high for exactly one
// cycle; the receiver cannot hold it off and must take it then.
// Sequence after the accepting edge: clear goes from the execute state
// straight to done; append and rewind then fetch the cursor entry and
// check it (rewind on an empty table skips the fetch); advance repeats
// fetch and check for each entry the cursor steps over; advance on an
// empty table goes straight to done.
// busy falls right after done_o, so the next item can be taken then.
// Each entry stepped costs one registered read of the single-port entry
// memory and one shared subtract/compare.
// Reset (rst_ni low, asynchronous) empties the table and zeroes cursor,
// elapsed time and total; memory contents are left as they are and are
// never read before being written.
module timed_sequence_cursor import tsc_pkg::*; #(
  parameter int unsigned ENTRY_DEPTH = ENTRY_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd_i,
  input  logic [DUR_W-1:0]   entry_duration_i,
  input  logic [TYPE_W-1:0]  entry_type_i,
  input  logic [DUR_W-1:0]   time_step_i,
  output logic               done_o,
  output logic [TYPE_W-1:0]  current_type_o,
  output logic [IDX_O_W-1:0] current_index_o,
  output logic [TOTAL_W-1:0] total_duration_o,
  output logic               at_last_entry_o,
  output logic [1:0]         status_o
);

  localparam int unsigned CNT_W = $clog2(ENTRY_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(ENTRY_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   cursor_q, cursor_d;
  logic [DUR_W-1:0]   elapsed_q, elapsed_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [1:0]         status_q, status_d;

  cmd_e               cmd_q;
  logic [DUR_W-1:0]   dur_q;
  logic [TYPE_W-1:0]  typ_q;
  logic [DUR_W-1:0]   step_q;

  entry_t             mem_q [ENTRY_DEPTH];
  entry_t             rd_q;
  logic               mem_we;
  logic               mem_re;

  alu_op_e            alu_op;
  logic [TOTAL_W-1:0] alu_a;
  logic [DUR_W-1:0]   alu_b;
  alu_res_t           alu_res;

  logic               accept;
  logic               full;
  logic [CNT_W-1:0]   next_pos;
  logic               has_next;
  logic [IDX_W+IDX_O_W-1:0] cursor_ext;

  assign accept   = start && !busy;
  assign full     = (count_q == CNT_W'(ENTRY_DEPTH));
  assign next_pos = CNT_W'(cursor_q) + CNT_W'(1);
  assign has_next = (next_pos < count_q);

  tsc_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    cursor_d  = cursor_q;
    elapsed_d = elapsed_q;
    total_d   = total_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    alu_op    = ALU_SUB;
    alu_a     = TOTAL_W'(elapsed_q);
    alu_b     = rd_q.dur;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (cmd_q)
          CMD_APPEND: begin
            alu_op = ALU_ADD38;
            alu_a  = total_q;
            alu_b  = dur_q;
            if (full) begin
              status_d = ST_FULL;
            end else begin
              mem_we  = 1'b1;
              total_d = alu_res.value;
              count_d = count_q + CNT_W'(1);
            end
            state_d = S_READ;
          end
          CMD_ADVANCE: begin
            alu_op = ALU_ADD32;
            alu_b  = step_q;
            if (count_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              elapsed_d = alu_res.value[DUR_W-1:0];
              state_d   = S_READ;
            end
          end
          CMD_REWIND: begin
            cursor_d  = '0;
            elapsed_d = '0;
            state_d   = S_READ;
          end
          CMD_CLEAR: begin
            count_d   = '0;
            cursor_d  = '0;
            elapsed_d = '0;
            total_d   = '0;
            state_d   = S_DONE;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_READ: begin
        // skip the fetch when nothing is stored
        if (count_q == '0) begin
          state_d = S_DONE;
        end else begin
          mem_re  = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        // on advance, step over the entry while time runs past it and one follows
        if ((cmd_q == CMD_ADVANCE) && alu_res.gt && has_next) begin
          elapsed_d = alu_res.value[DUR_W-1:0];
          cursor_d  = cursor_q + IDX_W'(1);
          state_d   = S_READ;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      cursor_q  <= '0;
      elapsed_q <= '0;
      total_q   <= '0;
      status_q  <= ST_OK;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cursor_q  <= cursor_d;
      elapsed_q <= elapsed_d;
      total_q   <= total_d;
      status_q  <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_e'(cmd_i);
      dur_q  <= entry_duration_i;
      typ_q  <= entry_type_i;
      step_q <= time_step_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[IDX_W-1:0]] <= '{dur: dur_q, typ: typ_q};
    end
    if (mem_re) begin
      rd_q <= mem_q[cursor_q];
    end
  end

  assign cursor_ext = (IDX_W+IDX_O_W)'(cursor_q);

  assign busy             = (state_q != S_IDLE);
  assign done_o           = (state_q == S_DONE);
  assign current_type_o   = (count_q != '0) ? rd_q.typ : '0;
  assign current_index_o  = cursor_ext[IDX_O_W-1:0];
  assign total_duration_o = total_q;
  assign at_last_entry_o  = (count_q != '0) && (next_pos == count_q);
  assign status_o         = status_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(ENTRY_DEPTH))
    else $error("entry count beyond table depth");

  a_cursor_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (next_pos <= count_q))
    else $error("cursor past last stored entry");

  a_cursor_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (cursor_q == '0))
    else $error("cursor nonzero on empty table");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result not followed by idle");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL)) |-> full)
    else $error("full status with room in table");

endmodule

// ===== tb/tb_timed_sequence_cursor.sv =====
// Self-checking testbench for timed_sequence_cursor: start/busy command side,
// done_o result strobe, checked against a cycle-free table/cursor tracker.
// Depends on tsc_pkg and the timed_sequence_cursor RTL.
module tb_timed_sequence_cursor;
  import tsc_pkg::*;

  localparam int unsigned DEPTH       = ENTRY_DEPTH_DEF;
  localparam int unsigned ITEM_TARGET = 1800;
  localparam int unsigned IDLE_LIMIT  = 3000;
  localparam int unsigned DRAIN       = 200;

  typedef struct packed {
    logic [TYPE_W-1:0]  ctype;
    logic [IDX_O_W-1:0] idx;
    logic [TOTAL_W-1:0] total;
    logic               last;
    logic [1:0]         status;
  } report_t;

  // Tracks the entry table and cursor; one report per accepted command.
  class cursor_tracker;
    logic [DUR_W-1:0]   dur_mem [DEPTH];
    logic [TYPE_W-1:0]  type_mem [DEPTH];
    int unsigned        count;
    int unsigned        cursor;
    logic [DUR_W-1:0]   elapsed;
    logic [TOTAL_W-1:0] total;
    report_t            due_reports[$];
    int unsigned        mismatches;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        dur_mem[i]  = '0;
        type_mem[i] = '0;
      end
      count      = 0;
      cursor     = 0;
      elapsed    = '0;
      total      = '0;
      mismatches = 0;
    endfunction

    function void note_command(cmd_e cmd, logic [DUR_W-1:0] dur, logic [TYPE_W-1:0] typ,
                               logic [DUR_W-1:0] step);
      logic [1:0]       st;
      logic [TOTAL_W:0] sum;
      logic [DUR_W:0]   t;
      report_t          rep;
      st = ST_OK;
      case (cmd)
        CMD_APPEND: begin
          if (count >= DEPTH) begin
            st = ST_FULL;
          end else begin
            dur_mem[count]  = dur;
            type_mem[count] = typ;
            count++;
            sum = {1'b0, total} + (TOTAL_W+1)'(dur);
            total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
          end
        end
        CMD_ADVANCE: begin
          if (count == 0) begin
            st = ST_EMPTY;
          end else begin
            t = {1'b0, elapsed} + {1'b0, step};
            elapsed = t[DUR_W] ? '1 : t[DUR_W-1:0];
            // only a strictly greater elapsed time moves past an entry
            while (elapsed > dur_mem[cursor] && cursor + 1 < count) begin
              elapsed = elapsed - dur_mem[cursor];
              cursor++;
            end
          end
        end
        CMD_REWIND: begin
          cursor  = 0;
          elapsed = '0;
        end
        default: begin
          count   = 0;
          cursor  = 0;
          elapsed = '0;
          total   = '0;
        end
      endcase
      rep.ctype  = (count > 0) ? type_mem[cursor] : '0;
      rep.idx    = IDX_O_W'(cursor);
      rep.total  = total;
      rep.last   = (count > 0) && (cursor + 1 == count);
      rep.status = st;
      due_reports = {due_reports, rep};
    endfunction

    function void check_report(report_t got);
      report_t exp_r;
      if (due_reports.size() == 0) begin
        $display("%0t: result with nothing pending: expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      exp_r = due_reports.pop_front();
      if (got.ctype !== exp_r.ctype) begin
        $display("%0t: current_type expected %h actual %h", $time, exp_r.ctype, got.ctype);
        mismatches++;
      end
      if (got.idx !== exp_r.idx) begin
        $display("%0t: current_index expected %0d actual %0d", $time, exp_r.idx, got.idx);
        mismatches++;
      end
      if (got.total !== exp_r.total) begin
        $display("%0t: total_duration expected %h actual %h", $time, exp_r.total, got.total);
        mismatches++;
      end
      if (got.last !== exp_r.last) begin
        $display("%0t: at_last_entry expected %b actual %b", $time, exp_r.last, got.last);
        mismatches++;
      end
      if (got.status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         cmd_i = CMD_APPEND;
  logic [DUR_W-1:0]   entry_duration_i = '0;
  logic [TYPE_W-1:0]  entry_type_i = '0;
  logic [DUR_W-1:0]   time_step_i = '0;
  logic               done_o;
  logic [TYPE_W-1:0]  current_type_o;
  logic [IDX_O_W-1:0] current_index_o;
  logic [TOTAL_W-1:0] total_duration_o;
  logic               at_last_entry_o;
  logic [1:0]         status_o;

  cursor_tracker tracker;
  int unsigned   items_sent = 0;
  int unsigned   idle_cycles = 0;
  bit            no_idle = 1'b0;

  timed_sequence_cursor dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cmd_i            (cmd_i),
    .entry_duration_i (entry_duration_i),
    .entry_type_i     (entry_type_i),
    .time_step_i      (time_step_i),
    .done_o           (done_o),
    .current_type_o   (current_type_o),
    .current_index_o  (current_index_o),
    .total_duration_o (total_duration_o),
    .at_last_entry_o  (at_last_entry_o),
    .status_o         (status_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      tracker.check_report({current_type_o, current_index_o, total_duration_o,
                            at_last_entry_o, status_o});
    end
  end

  // Reset the count whenever an item or a result moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timed_sequence_cursor verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4, 5: return $urandom_range(1, 64);
      6, 7:    return $urandom_range(0, 4096);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DUR_W-1:0] pick_step();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4, 5, 6: return $urandom_range(0, 200);
      7, 8:    return $urandom_range(0, 20000);
      default: return $urandom;
    endcase
  endfunction

  // Hold the item until the block takes it; note it at the accepting edge.
  task automatic send_item(cmd_e c, logic [DUR_W-1:0] d, logic [TYPE_W-1:0] t,
                           logic [DUR_W-1:0] s);
    int unsigned gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start            <= 1'b1;
    cmd_i            <= c;
    entry_duration_i <= d;
    entry_type_i     <= t;
    time_step_i      <= s;
    do @(posedge clk_i); while (busy);
    tracker.note_command(c, d, t, s);
    items_sent++;
  endtask

  task automatic send_noise(int unsigned n);
    repeat (n) send_item(cmd_e'($urandom_range(0, 3)), $urandom, TYPE_W'($urandom), $urandom);
  endtask

  initial begin
    int unsigned n;
    int unsigned r;
    tracker = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, extremes, equal time, saturation and the last entry
    send_item(CMD_ADVANCE, $urandom, TYPE_W'($urandom), '1);
    send_item(CMD_REWIND, $urandom, TYPE_W'($urandom), $urandom);
    send_item(CMD_CLEAR, $urandom, TYPE_W'($urandom), $urandom);
    send_item(CMD_APPEND, '0, '0, $urandom);
    send_item(CMD_APPEND, '1, '1, $urandom);
    send_item(CMD_APPEND, 32'd10, 16'h1234, $urandom);
    send_item(CMD_ADVANCE, $urandom, TYPE_W'($urandom), '0);
    send_item(CMD_ADVANCE, $urandom, TYPE_W'($urandom), 32'd1);
    send_item(CMD_ADVANCE, $urandom, TYPE_W'($urandom), 32'hFFFF_FFFE);
    send_item(CMD_ADVANCE, $urandom, TYPE_W'($urandom), '1);
    send_item(CMD_REWIND, $urandom, TYPE_W'($urandom), $urandom);
    send_item(CMD_ADVANCE, $urandom, TYPE_W'($urandom), '1);
    send_item(CMD_CLEAR, $urandom, TYPE_W'($urandom), $urandom);
    send_item(CMD_APPEND, 32'd5, 16'hA5A5, $urandom);
    send_item(CMD_APPEND, 32'd5, 16'h5A5A, $urandom);
    send_item(CMD_ADVANCE, $urandom, TYPE_W'($urandom), 32'd5);
    send_item(CMD_ADVANCE, $urandom, TYPE_W'($urandom), 32'd1);
    send_item(CMD_ADVANCE, $urandom, TYPE_W'($urandom), 32'hFFFF_FFF0);
    send_item(CMD_ADVANCE, $urandom, TYPE_W'($urandom), 32'h100);
    send_item(CMD_APPEND, 32'd7, 16'h0001, $urandom);
    send_item(CMD_ADVANCE, $urandom, TYPE_W'($urandom), '0);
    send_item(CMD_CLEAR, $urandom, TYPE_W'($urandom), $urandom);

    n = items_sent + ITEM_TARGET;
    while (items_sent < n) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        // build a table, then play it back; long fills can run into a full table
        if ($urandom_range(0, 1) == 1) begin
          send_item(CMD_CLEAR, $urandom, TYPE_W'($urandom), $urandom);
        end
        r = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 8);
        repeat (r) send_item(CMD_APPEND, pick_duration(), TYPE_W'($urandom), $urandom);
        repeat ($urandom_range(2, 12)) begin
          case ($urandom_range(0, 9))
            0:       send_item(CMD_REWIND, $urandom, TYPE_W'($urandom), $urandom);
            1:       send_item(CMD_APPEND, pick_duration(), TYPE_W'($urandom), $urandom);
            default: send_item(CMD_ADVANCE, $urandom, TYPE_W'($urandom), pick_step());
          endcase
        end
      end else begin
        send_noise($urandom_range(1, 10));
      end
    end
    start <= 1'b0;

    while (tracker.due_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("timed_sequence_cursor verification clean");
    end else begin
      $display("timed_sequence_cursor verification failed");
    end
    $finish;
  end

endmodule
